// ===== design/efwp_pkg.sv =====
// Package for the earliest-finish worker picker: item types, command and
// status structs, codes and saturating time helpers. No dependencies.
`default_nettype none

package efwp_pkg;

  localparam int WORKER_COUNT_DEF = 4;
  localparam int INPUT_WORKERS    = 4;
  localparam int TIME_W           = 40;
  localparam int EST_W            = 32;
  localparam int ACTIVE_W         = 3;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd4;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  typedef logic [TIME_W-1:0] time_t;

  typedef struct packed {
    logic        operation;
    logic [31:0] now_time;
    logic [1:0]  pop_worker;
    logic [31:0] pop_length;
    logic [3:0]  eligible_mask;
    logic [3:0]  unknown_mask;
    logic [31:0] est_0;
    logic [31:0] est_1;
    logic [31:0] est_2;
    logic [31:0] est_3;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  chosen_worker;
    logic [31:0] assigned_length;
    logic        status;
  } out_item_t;

  typedef logic [ACTIVE_W-1:0] cfg_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the accepted item and clear the scan state
    logic scan;      // advance the two-stage worker scan by one step
    logic push_fin;  // charge the winner and load the result register
    logic pop_upd;   // update length and start of the popped worker
    logic pop_fin;   // update end of the popped worker and load the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_is_pop;  // operation field of the item offered on the input
    logic scan_done;   // scan finished or stopped on a worker with no estimate
    logic out_free;    // result register can take a new result this cycle
  } status_t;

  function automatic time_t sat_add(input time_t a, input time_t b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  function automatic time_t max_time(input time_t a, input time_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// ===== design/efwp_stream_if.sv =====
// Valid/ready channel interface used by the picker's request, result and
// configuration ports. The payload type is a parameter.
`default_nettype none

interface efwp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/efwp_ctrl.sv =====
// Controller state machine of the picker. It sequences the datapath through
// the push scan or the pop update. Depends on efwp_pkg.
`default_nettype none

module efwp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire efwp_pkg::status_t status,
  output efwp_pkg::cmd_t        cmd
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_SCAN     = 5'b00010,
    S_PUSH_FIN = 5'b00100,
    S_POP_UPD  = 5'b01000,
    S_POP_FIN  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.req_is_pop ? S_POP_UPD : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = S_PUSH_FIN;
        end
      end
      S_PUSH_FIN: begin
        if (status.out_free) begin
          cmd.push_fin = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_POP_UPD: begin
        cmd.pop_upd = 1'b1;
        state_next  = S_POP_FIN;
      end
      S_POP_FIN: begin
        if (status.out_free) begin
          cmd.pop_fin = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/efwp_datapath.sv =====
// Datapath of the picker: per-worker time state, the two-stage scan, the
// pop arithmetic and the result register. Depends on efwp_pkg.
`default_nettype none

module efwp_datapath #(
  parameter int WORKER_COUNT = efwp_pkg::WORKER_COUNT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire efwp_pkg::cmd_t      cmd,
  output efwp_pkg::status_t        status,
  input  wire efwp_pkg::in_item_t  req_data,
  input  wire logic                cfg_valid,
  input  wire efwp_pkg::cfg_item_t cfg_data,
  output logic                     out_valid,
  output efwp_pkg::out_item_t      out_data,
  input  wire logic                out_ready
);

  localparam int IDX_W = (WORKER_COUNT > 1) ? $clog2(WORKER_COUNT) : 1;
  localparam int CNT_W = $clog2(WORKER_COUNT + 1);
  localparam int TW    = efwp_pkg::TIME_W;
  localparam int EW    = efwp_pkg::EST_W;

  efwp_pkg::cfg_item_t active_workers;
  efwp_pkg::in_item_t  item;

  efwp_pkg::time_t expected_start [WORKER_COUNT];
  efwp_pkg::time_t queued_length  [WORKER_COUNT];
  efwp_pkg::time_t expected_end   [WORKER_COUNT];

  // Scan position and the stage register between clamp and compare.
  logic [CNT_W-1:0] scan_idx;
  logic             pipe_valid;
  logic [IDX_W-1:0] pipe_idx;
  efwp_pkg::time_t  pipe_base;
  logic [EW-1:0]    pipe_est;

  // Running best candidate.
  logic             found;
  logic             hit;
  logic [IDX_W-1:0] best_idx;
  efwp_pkg::time_t  best_fin;
  logic [EW-1:0]    charge;

  logic [CNT_W-1:0] limit;
  logic [IDX_W-1:0] cur;
  logic [2:0]       cur_ext;
  logic             cur_elig;
  logic             cur_unk;
  logic [EW-1:0]    cur_est;
  logic             stage1_go;
  logic             stage1_hit;
  efwp_pkg::time_t  now_ext;
  efwp_pkg::time_t  start_cl;
  efwp_pkg::time_t  end_cl;
  efwp_pkg::time_t  fin;
  logic             fin_better;

  logic             pop_bad;
  logic [IDX_W-1:0] pop_idx;
  efwp_pkg::time_t  pop_len_ext;

  always_comb begin
    if (active_workers > efwp_pkg::ACTIVE_W'(WORKER_COUNT)) begin
      limit = CNT_W'(WORKER_COUNT);
    end else begin
      limit = CNT_W'(active_workers);
    end
  end

  assign cur     = scan_idx[IDX_W-1:0];
  assign cur_ext = 3'(cur);
  assign now_ext = TW'(item.now_time);

  always_comb begin
    cur_elig = 1'b0;
    cur_unk  = 1'b0;
    if (cur_ext < 3'(efwp_pkg::INPUT_WORKERS)) begin
      cur_elig = item.eligible_mask[cur_ext[1:0]];
      cur_unk  = item.unknown_mask[cur_ext[1:0]];
    end
    unique case (cur_ext[1:0])
      2'd0:    cur_est = item.est_0;
      2'd1:    cur_est = item.est_1;
      2'd2:    cur_est = item.est_2;
      default: cur_est = item.est_3;
    endcase
  end

  assign stage1_go  = cmd.scan && (scan_idx < limit) && !hit;
  assign stage1_hit = stage1_go && cur_elig && cur_unk;
  assign start_cl   = efwp_pkg::max_time(expected_start[cur], now_ext);
  assign end_cl     = efwp_pkg::max_time(expected_end[cur], now_ext);
  assign fin        = efwp_pkg::sat_add(pipe_base, TW'(pipe_est));
  assign fin_better = !found || (fin < best_fin);

  assign pop_bad     = {1'b0, item.pop_worker} >= 3'(WORKER_COUNT);
  assign pop_idx     = IDX_W'(item.pop_worker);
  assign pop_len_ext = TW'(item.pop_length);

  assign status.req_is_pop = (req_data.operation == efwp_pkg::OP_POP);
  assign status.scan_done  = hit || ((scan_idx >= limit) && !pipe_valid);
  assign status.out_free   = !out_valid || out_ready;

  // Configuration and item capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_workers <= efwp_pkg::ACTIVE_RESET;
    end else if (cfg_valid) begin
      active_workers <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= req_data;
    end
  end

  // Scan control.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      pipe_valid <= 1'b0;
      found      <= 1'b0;
      hit        <= 1'b0;
    end else if (cmd.load) begin
      scan_idx   <= '0;
      pipe_valid <= 1'b0;
      found      <= 1'b0;
      hit        <= 1'b0;
    end else if (cmd.scan) begin
      if (stage1_hit) begin
        hit        <= 1'b1;
        found      <= 1'b1;
        pipe_valid <= 1'b0;
      end else begin
        pipe_valid <= stage1_go && cur_elig;
        if (stage1_go) begin
          scan_idx <= scan_idx + CNT_W'(1);
        end
        if (pipe_valid && fin_better) begin
          found <= 1'b1;
        end
      end
    end
  end

  // Scan payload registers.
  always_ff @(posedge clk) begin
    if (stage1_go) begin
      pipe_idx  <= cur;
      pipe_base <= efwp_pkg::sat_add(start_cl, queued_length[cur]);
      pipe_est  <= cur_est;
    end
    if (stage1_hit) begin
      best_idx <= cur;
      charge   <= '0;
    end else if (cmd.scan && pipe_valid && fin_better) begin
      best_idx <= pipe_idx;
      best_fin <= fin;
      charge   <= pipe_est;
    end
  end

  // Worker state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < WORKER_COUNT; w++) begin
        expected_start[w] <= '0;
        queued_length[w]  <= '0;
        expected_end[w]   <= '0;
      end
    end else begin
      priority if (stage1_go) begin
        expected_start[cur] <= start_cl;
        expected_end[cur]   <= end_cl;
      end else if (cmd.push_fin && found) begin
        expected_end[best_idx]  <= efwp_pkg::sat_add(expected_end[best_idx], TW'(charge));
        queued_length[best_idx] <= efwp_pkg::sat_add(queued_length[best_idx], TW'(charge));
      end else if (cmd.pop_upd && !pop_bad) begin
        queued_length[pop_idx]  <= (queued_length[pop_idx] > pop_len_ext) ?
                                   queued_length[pop_idx] - pop_len_ext : '0;
        expected_start[pop_idx] <= efwp_pkg::sat_add(now_ext, pop_len_ext);
      end else if (cmd.pop_fin && !pop_bad) begin
        expected_end[pop_idx] <= efwp_pkg::sat_add(expected_start[pop_idx],
                                                   queued_length[pop_idx]);
      end else begin
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push_fin || cmd.pop_fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_fin) begin
      if (found) begin
        out_data.chosen_worker   <= 2'(best_idx);
        out_data.assigned_length <= charge;
        out_data.status          <= efwp_pkg::STATUS_OK;
      end else begin
        out_data.chosen_worker   <= '0;
        out_data.assigned_length <= '0;
        out_data.status          <= efwp_pkg::STATUS_ERROR;
      end
    end else if (cmd.pop_fin) begin
      out_data.chosen_worker   <= item.pop_worker;
      out_data.assigned_length <= pop_bad ? '0 : item.pop_length;
      out_data.status          <= pop_bad ? efwp_pkg::STATUS_ERROR : efwp_pkg::STATUS_OK;
    end
  end

endmodule

`default_nettype wire

// ===== design/earliest_finish_worker_picker_top.sv =====
// Top level of the earliest-finish worker picker. Depends on efwp_pkg,
// efwp_stream_if, efwp_ctrl and efwp_datapath.
//
// Usage: the block picks, for each pushed task, the worker that is expected
// to finish it first, and tracks per-worker start, queued length and end.
// The req channel carries one item per transfer: a push (eligibility and
// no-estimate masks plus one estimate per worker) or a pop (worker and the
// popped job's length). The rsp channel returns exactly one result per item.
// The cfg channel writes active_workers; it is always ready and must only be
// used while no item is in flight.
// Push: the scan visits one worker per cycle through a two-stage clamp/compare
// path and stops early at an eligible worker with no estimate. A pop first
// updates the worker's length and start, then its end. One item is worked
// on at a time; req is ready again in the cycle after the result is loaded.
// Stall: a finished result waits in the result register; a new item is
// accepted meanwhile and the block holds before its final step until the
// register is taken. Reset clears all worker times to zero, sets
// active_workers to 4 and empties the result register.
`default_nettype none

module earliest_finish_worker_picker_top #(
  parameter int WORKER_COUNT = efwp_pkg::WORKER_COUNT_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  efwp_stream_if.sink   req,
  efwp_stream_if.source rsp,
  efwp_stream_if.sink   cfg
);

  efwp_pkg::cmd_t    cmd;
  efwp_pkg::status_t status;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  efwp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  efwp_datapath #(
    .WORKER_COUNT (WORKER_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req_data  (req.data),
    .cfg_valid (cfg.valid),
    .cfg_data  (cfg.data),
    .out_valid (rsp.valid),
    .out_data  (rsp.data),
    .out_ready (rsp.ready)
  );

endmodule

`default_nettype wire

// ===== design/efwp_checker.sv =====
// Port-level checker for the picker, attached to the top level by bind.
// Depends on efwp_pkg and the top level's channel interfaces.
`default_nettype none

module efwp_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                req_valid,
  input wire logic                req_ready,
  input wire logic                rsp_valid,
  input wire logic                rsp_ready,
  input wire efwp_pkg::out_item_t rsp_data
);

  logic       req_xfer;
  logic       rsp_xfer;
  logic [1:0] pending;

  assign req_xfer = req_valid && req_ready;
  assign rsp_xfer = rsp_valid && rsp_ready;

  // Items taken in but whose result has not yet been delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(req_xfer) - 2'(rsp_xfer);
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("result without an outstanding item");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3 && !(pending == 2'd2 && req_xfer))
    else $error("too many items in flight");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == efwp_pkg::STATUS_ERROR |->
      rsp_data.assigned_length == 32'd0)
    else $error("error result carries a length");

endmodule

bind earliest_finish_worker_picker_top efwp_checker u_efwp_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

`default_nettype wire

// ===== test/tb_earliest_finish_worker_picker_top.sv =====
// Self-checking testbench for earliest_finish_worker_picker_top: a scoreboard class
// predicts every pick and pop, and plain tasks drive the req, rsp and cfg channels.
// Depends on efwp_pkg, efwp_stream_if and the design files under design/.
`timescale 1ns / 100ps

module tb_earliest_finish_worker_picker_top;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PER_PHASE = 200;
  localparam int PILEUP_PUSHES = 270;
  localparam int PHASE_COUNT = 8;
  localparam int TW = efwp_pkg::TIME_W;
  localparam int NW = efwp_pkg::INPUT_WORKERS;

  // Scoreboard: a cycle-free model of the per-worker timeline plus the queue
  // of results that the block still owes.
  class finish_time_scoreboard;
    efwp_pkg::time_t start_at[NW];
    efwp_pkg::time_t queued[NW];
    efwp_pkg::time_t finish_at[NW];
    efwp_pkg::cfg_item_t active;
    efwp_pkg::out_item_t awaited_picks[$];
    int unsigned mismatches;

    function new();
      for (int w = 0; w < NW; w++) begin
        start_at[w] = '0;
        queued[w] = '0;
        finish_at[w] = '0;
      end
      active = efwp_pkg::ACTIVE_RESET;
      mismatches = 0;
    endfunction

    // Time sums clip at the top of the 40-bit range instead of wrapping.
    function efwp_pkg::time_t clip_sum(efwp_pkg::time_t a, efwp_pkg::time_t b);
      logic [TW:0] wide;
      wide = (TW + 1)'(a) + (TW + 1)'(b);
      if (wide > (TW + 1)'({TW{1'b1}})) return {TW{1'b1}};
      return wide[TW-1:0];
    endfunction

    function void set_active(efwp_pkg::cfg_item_t value);
      active = value;
    endfunction

    function int pending();
      return awaited_picks.size();
    endfunction

    function void note_request(efwp_pkg::in_item_t item);
      efwp_pkg::out_item_t pick;
      logic [31:0] dur [NW];
      efwp_pkg::time_t now_t, pop_len, fin, best_fin, charge;
      int scan_len, best;
      bit found;
      now_t = {8'd0, item.now_time};
      pick = '0;
      if (item.operation == efwp_pkg::OP_POP) begin
        // Popping re-bases the worker on now plus the popped job's length.
        pop_len = {8'd0, item.pop_length};
        queued[item.pop_worker] = (queued[item.pop_worker] > pop_len) ?
                                  queued[item.pop_worker] - pop_len : '0;
        start_at[item.pop_worker] = clip_sum(now_t, pop_len);
        finish_at[item.pop_worker] = clip_sum(start_at[item.pop_worker],
                                              queued[item.pop_worker]);
        pick.chosen_worker = item.pop_worker;
        pick.assigned_length = item.pop_length;
        pick.status = efwp_pkg::STATUS_OK;
      end else begin
        dur[0] = item.est_0;
        dur[1] = item.est_1;
        dur[2] = item.est_2;
        dur[3] = item.est_3;
        scan_len = (active > efwp_pkg::WORKER_COUNT_DEF) ? efwp_pkg::WORKER_COUNT_DEF :
                   int'(active);
        found = 1'b0;
        best = 0;
        best_fin = '0;
        charge = '0;
        for (int w = 0; w < scan_len; w++) begin
          if (start_at[w] < now_t) start_at[w] = now_t;
          if (finish_at[w] < now_t) finish_at[w] = now_t;
          if (w < NW && item.eligible_mask[w]) begin
            // A worker with no estimate ends the scan on the spot.
            if (item.unknown_mask[w]) begin
              found = 1'b1;
              best = w;
              charge = '0;
              break;
            end
            fin = clip_sum(clip_sum(start_at[w], queued[w]), {8'd0, dur[w]});
            if (!found || fin < best_fin) begin
              found = 1'b1;
              best = w;
              best_fin = fin;
              charge = {8'd0, dur[w]};
            end
          end
        end
        if (found) begin
          finish_at[best] = clip_sum(finish_at[best], charge);
          queued[best] = clip_sum(queued[best], charge);
          pick.chosen_worker = 2'(best);
          pick.assigned_length = charge[31:0];
          pick.status = efwp_pkg::STATUS_OK;
        end else begin
          pick.status = efwp_pkg::STATUS_ERROR;
        end
      end
      awaited_picks.push_back(pick);
    endfunction

    function void check_pick(efwp_pkg::out_item_t got);
      efwp_pkg::out_item_t want;
      if (awaited_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: worker %0d length %0h status %0d",
                   got.chosen_worker, got.assigned_length, got.status);
        return;
      end
      want = awaited_picks.pop_front();
      if (got.chosen_worker !== want.chosen_worker ||
          got.assigned_length !== want.assigned_length ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"pick differs: worker exp %0d got %0d, length exp %0h got %0h, ",
                    "status exp %0d got %0d"},
                   want.chosen_worker, got.chosen_worker, want.assigned_length,
                   got.assigned_length, want.status, got.status);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  efwp_stream_if #(.payload_t(efwp_pkg::in_item_t))  req_if ();
  efwp_stream_if #(.payload_t(efwp_pkg::out_item_t)) rsp_if ();
  efwp_stream_if #(.payload_t(efwp_pkg::cfg_item_t)) cfg_if ();

  earliest_finish_worker_picker_top u_top (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg(cfg_if)
  );

  finish_time_scoreboard board = new();

  // Random idling on both channels is switched off for the last phase.
  bit idling_on = 1'b1;
  logic [31:0] clock_now = '0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Result side: random back-pressure in bursts, and every transfer on rsp is
  // checked against the oldest outstanding prediction. Values are sampled at
  // the edge, before any of this edge's updates land.
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) board.check_pick(rsp_if.data);
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_if.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 16);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Watchdog: any transfer on any channel counts as progress. A long quiet
  // stretch means the block has hung.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("earliest_finish_worker_picker_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item on req, optionally after a random gap, and hand it to the
  // scoreboard once the transfer happens. Valid stays high afterwards so a
  // back-to-back item follows without a gap; the caller lowers it.
  task automatic send_request(input efwp_pkg::in_item_t item);
    int gap;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data <= item;
    do @(posedge clk); while (!req_if.ready);
    board.note_request(item);
  endtask

  // Stop offering items and wait until every predicted result has arrived.
  task automatic wait_until_drained();
    req_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_active_workers(input efwp_pkg::cfg_item_t value);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    board.set_active(value);
  endtask

  function automatic efwp_pkg::in_item_t make_push(input logic [31:0] now_t,
                                                   input logic [3:0] elig,
                                                   input logic [3:0] unk,
                                                   input logic [31:0] e0,
                                                   input logic [31:0] e1,
                                                   input logic [31:0] e2,
                                                   input logic [31:0] e3);
    efwp_pkg::in_item_t item;
    item = '0;
    item.operation = efwp_pkg::OP_PUSH;
    item.now_time = now_t;
    item.eligible_mask = elig;
    item.unknown_mask = unk;
    item.est_0 = e0;
    item.est_1 = e1;
    item.est_2 = e2;
    item.est_3 = e3;
    return item;
  endfunction

  function automatic efwp_pkg::in_item_t make_pop(input logic [31:0] now_t,
                                                  input logic [1:0] worker,
                                                  input logic [31:0] len);
    efwp_pkg::in_item_t item;
    item = '0;
    item.operation = efwp_pkg::OP_POP;
    item.now_time = now_t;
    item.pop_worker = worker;
    item.pop_length = len;
    return item;
  endfunction

  // Time mostly creeps forward so that queues build up against each other;
  // now and then it jumps anywhere, or to the top of the 32-bit range.
  function automatic logic [31:0] next_now();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) clock_now = $urandom;
    else if (roll < 3) clock_now = 32'hFFFF_FFF0 + $urandom_range(0, 15);
    else clock_now = clock_now + $urandom_range(0, 40);
    return clock_now;
  endfunction

  // Durations: mostly short so that finish times compete, some long, some at
  // the maximum to push the 40-bit sums toward saturation.
  function automatic logic [31:0] pick_duration();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return $urandom_range(0, 200);
    if (roll < 80) return $urandom_range(0, 100000);
    if (roll < 95) return $urandom;
    return 32'hFFFF_FFFF;
  endfunction

  function automatic efwp_pkg::in_item_t random_item();
    efwp_pkg::in_item_t item;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    item.now_time = next_now();
    item.pop_worker = 2'($urandom);
    item.pop_length = $urandom;
    item.eligible_mask = 4'($urandom);
    item.unknown_mask = 4'($urandom);
    item.est_0 = $urandom;
    item.est_1 = $urandom;
    item.est_2 = $urandom;
    item.est_3 = $urandom;
    if (roll < 55) begin
      // Well-formed push: usually something eligible, usually all estimated.
      item.operation = efwp_pkg::OP_PUSH;
      item.eligible_mask = ($urandom_range(0, 19) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
      item.unknown_mask = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'h0;
      item.est_0 = pick_duration();
      item.est_1 = pick_duration();
      item.est_2 = pick_duration();
      item.est_3 = pick_duration();
    end else if (roll < 90) begin
      item.operation = efwp_pkg::OP_POP;
      item.pop_length = ($urandom_range(0, 9) == 0) ? 32'd0 : pick_duration();
    end else begin
      // Noise: every field fully random, the operation included.
      item.operation = 1'($urandom);
    end
    return item;
  endfunction

  // The run goes through these active_workers settings in order: the reset
  // value, a single worker, none at all, a value above the worker count, the
  // ones in between, another value above it, and the reset value again.
  efwp_pkg::cfg_item_t phase_setting [PHASE_COUNT] =
    '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd4};

  initial begin
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      if (phase == PHASE_COUNT - 1) idling_on = 1'b0;
      write_active_workers(phase_setting[phase]);

      if (phase == 0) begin
        // Directed cases with all four workers scanned, starting from reset.
        // No eligible worker at all: error status, clamping only.
        send_request(make_push(32'd0, 4'h0, 4'h0, 32'd7, 32'd7, 32'd7, 32'd7));
        // Every worker finishes at zero: the tie goes to worker 0.
        send_request(make_push(32'd0, 4'hF, 4'h0, 32'd0, 32'd0, 32'd0, 32'd0));
        // Equal finish times on workers 1 and 2: the lower index wins.
        send_request(make_push(32'd10, 4'hF, 4'h0, 32'd5, 32'd3, 32'd3, 32'd9));
        // A known candidate first, then a worker with no estimate that wins.
        send_request(make_push(32'd12, 4'b1010, 4'b1000, 32'd1, 32'd2, 32'd3, 32'd4));
        // Scan stops early at worker 1; workers 2 and 3 stay unclamped.
        send_request(make_push(32'd20, 4'hF, 4'b0010, 32'd1, 32'd1, 32'd1, 32'd1));
        // A no-estimate bit on an ineligible worker is ignored.
        send_request(make_push(32'd21, 4'b0001, 4'b1110, 32'd4, 32'd0, 32'd0, 32'd0));
        // Everything unknown: worker 0 wins with length zero.
        send_request(make_push(32'd22, 4'hF, 4'hF, 32'd9, 32'd9, 32'd9, 32'd9));
        // Only the last worker eligible.
        send_request(make_push(32'd23, 4'b1000, 4'h0, 32'd0, 32'd0, 32'd0, 32'd50));
        // Largest time and estimates everywhere.
        send_request(make_push(32'hFFFF_FFFF, 4'hF, 4'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_push(32'hFFFF_FFFF, 4'b0110, 4'h0, 32'hFFFF_FFFF, 32'd1,
                               32'hFFFF_FFFF, 32'd0));
        // Pops: zero length, a length beyond the queue, a partial one, time zero.
        send_request(make_pop(32'hFFFF_FFFF, 2'd3, 32'd0));
        send_request(make_pop(32'hFFFF_FFFF, 2'd0, 32'hFFFF_FFFF));
        send_request(make_pop(32'd100, 2'd1, 32'd1));
        send_request(make_pop(32'd0, 2'd2, 32'd5));
        // Time going backwards against the clamped workers.
        send_request(make_push(32'd0, 4'hF, 4'h0, 32'd3, 32'd2, 32'd1, 32'd0));
      end

      if (phase_setting[phase] == 3'd1) begin
        // Pile enough maximal work on worker 0 that its 40-bit length and end
        // saturate, so the random items that follow run against clipped sums.
        for (int n = 0; n < PILEUP_PUSHES; n++)
          send_request(make_push(next_now(), 4'($urandom_range(0, 15)) | 4'b0001, 4'h0,
                                 32'hFFFF_FFFF, $urandom, $urandom, $urandom));
      end

      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_request(random_item());

      // The register may only be written with nothing in flight.
      wait_until_drained();
    end

    // Give the block time to show any stray result after the last one.
    repeat (16) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("earliest_finish_worker_picker_top: match");
    end else begin
      $display("earliest_finish_worker_picker_top: mismatch");
    end
    $finish;
  end

endmodule
